FILE: rtl/core/wsola_pkg.sv
// ----------------------------------------------------------------------------
// wsola_pkg
// Shared constants, register codes and controller/datapath interface types
// for the two-grain pitch shifter.
// ----------------------------------------------------------------------------
package wsola_pkg;

  localparam int DEPTH    = 8192;
  localparam int ADDR_W   = 13;
  localparam int FRAC_W   = 13;
  localparam int POS_W    = ADDR_W + FRAC_W;
  localparam int SAMPLE_W = 24;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 2;

  localparam logic [IDX_W-1:0] REG_PITCH = 2'd0;
  localparam logic [IDX_W-1:0] REG_WET   = 2'd1;
  localparam logic [IDX_W-1:0] REG_LEVEL = 2'd2;

  localparam logic [CFG_W-1:0] PITCH_RST  = 16'd4096;
  localparam logic [CFG_W-1:0] WET_RST    = 16'd16384;
  localparam logic [CFG_W-1:0] LEVEL_RST  = 16'd26214;
  localparam logic [CFG_W-1:0] UNITY      = 16'd8192;
  localparam logic [CFG_W-1:0] BYPASS_TOL = 16'd40;
  localparam logic [CFG_W-1:0] RATIO_MIN  = 16'd2048;
  localparam logic [CFG_W-1:0] RATIO_MAX  = 16'd32768;
  localparam logic [CFG_W-1:0] GAIN_MAX   = 16'd32768;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic clr_write;
    logic latch_in;
    logic bypass_mul;
    logic write_sample;
    logic grain_read;
    logic interp;
    logic wmul;
    logic grain_upd;
    logic next_grain;
    logic srch_init;
    logic corr_issue;
    logic srch_comp;
    logic srch_end;
    logic mix1;
    logic mix2;
    logic mix3;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bypass;
    logic grain_end;
    logic gsel;
    logic tap_last;
    logic pipe_busy;
    logic cand_last;
  } status_t;

endpackage

FILE: rtl/core/wsola_dp.sv
// ----------------------------------------------------------------------------
// wsola_dp
// Datapath: configuration registers, delay line memory, window table, grain
// interpolation, correlation search and dry/wet mixing with saturation.
// ----------------------------------------------------------------------------
module wsola_dp #(
  parameter int GRAIN_LEN    = 1024,
  parameter int CORR_TAPS    = 64,
  parameter int SEARCH_RANGE = 150
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [wsola_pkg::IDX_W-1:0]              cfg_index,
  input  logic [wsola_pkg::CFG_W-1:0]              cfg_data,
  input  logic signed [wsola_pkg::SAMPLE_W-1:0]    sample_in,
  output logic signed [wsola_pkg::SAMPLE_W-1:0]    sample_out,
  input  wsola_pkg::cmd_t                          cmd,
  output wsola_pkg::status_t                       status
);
  import wsola_pkg::*;

  localparam int PH_W    = $clog2(GRAIN_LEN);
  localparam int K_W     = $clog2(CORR_TAPS);
  localparam int D_W     = $clog2(2 * SEARCH_RANGE + 1);
  localparam int SCORE_W = 2 * SAMPLE_W + K_W;
  localparam int HALF    = GRAIN_LEN / 2;
  localparam logic [POS_W-1:0]  POS_A_RST = POS_W'(DEPTH / 2 - GRAIN_LEN) << FRAC_W;
  localparam logic [POS_W-1:0]  POS_B_RST = POS_W'(DEPTH / 2 - HALF) << FRAC_W;
  localparam logic [ADDR_W-1:0] WI_RST    = ADDR_W'(DEPTH / 2);

  function automatic logic [15:0] hann_value(input int unsigned k);
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sq;
    logic [63:0] q;
    logic signed [63:0] s;
    m = (k <= GRAIN_LEN / 2) ? 64'(k) : 64'(GRAIN_LEN - k);
    x = (PI_Q30 * m) / 64'(GRAIN_LEN);
    x2 = (x * x) >> 30;
    term = x;
    s = $signed(x);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - $signed(term);
      else s = s + $signed(term);
    end
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    sq = ($unsigned(s) * $unsigned(s)) >> 30;
    q = (sq + 64'd16384) >> 15;
    if (q > 64'd32768) q = 64'd32768;
    return q[15:0];
  endfunction

  // configuration
  logic [CFG_W-1:0] shift_ratio, wet_mix, output_level;
  logic [CFG_W-1:0] ratio_c, mix_c, level_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_ratio  <= PITCH_RST;
      wet_mix      <= WET_RST;
      output_level <= LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PITCH: shift_ratio  <= cfg_data;
        REG_WET:   wet_mix      <= cfg_data;
        REG_LEVEL: output_level <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ratio_c = (shift_ratio < RATIO_MIN) ? RATIO_MIN :
                   (shift_ratio > RATIO_MAX) ? RATIO_MAX : shift_ratio;
  assign mix_c   = (wet_mix > GAIN_MAX) ? GAIN_MAX : wet_mix;
  assign level_c = (output_level > GAIN_MAX) ? GAIN_MAX : output_level;

  // window table
  logic [15:0] win_tab [GRAIN_LEN];
  for (genvar gi = 0; gi < GRAIN_LEN; gi++) begin : g_win
    assign win_tab[gi] = hann_value(gi);
  end

  // control registers
  logic [ADDR_W-1:0]          clr_cnt;
  logic [ADDR_W-1:0]          wi;
  logic                       gsel;
  logic [POS_W-1:0]           pos_a, pos_b;
  logic [PH_W-1:0]            ph_a, ph_b;
  logic                       byp;
  logic [K_W-1:0]             k;
  logic [D_W-1:0]             d;
  logic                       have;
  logic                       v1, v2;

  // payload registers
  logic signed [SAMPLE_W-1:0] x;
  logic [ADDR_W-1:0]          src, cand, best_pos;
  logic signed [SCORE_W-1:0]  score, best;
  logic signed [2*SAMPLE_W-1:0] cprod_q;
  logic [15:0]                win_q;
  logic [FRAC_W-1:0]          frac_q;
  logic signed [38:0]         interp_q;
  logic signed [55:0]         wprod_q;
  logic signed [40:0]         ga, gb;
  logic signed [40:0]         p1_q;
  logic signed [58:0]         p2_q;
  logic signed [46:0]         mixq_q;
  logic signed [63:0]         fin_q;

  // delay line
  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_a, rd_b;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr, rd_addr_a, rd_addr_b;
  logic signed [SAMPLE_W-1:0] wr_data;

  logic [POS_W-1:0]           pos_sel;
  logic [PH_W-1:0]            ph_sel, ph_next;
  logic [ADDR_W-1:0]          pos_i;
  logic [28:0]                glen_prod;
  logic [ADDR_W-1:0]          ideal;

  assign pos_sel = gsel ? pos_b : pos_a;
  assign ph_sel  = gsel ? ph_b : ph_a;
  assign ph_next = (ph_sel == PH_W'(GRAIN_LEN - 1)) ? '0 : ph_sel + 1'b1;
  assign pos_i   = pos_sel[POS_W-1:FRAC_W];

  assign wr_en     = cmd.clr_write | cmd.write_sample;
  assign wr_addr   = cmd.clr_write ? clr_cnt : wi;
  assign wr_data   = cmd.clr_write ? '0 : x;
  assign rd_addr_a = cmd.corr_issue ? src + ADDR_W'(k) : pos_i;
  assign rd_addr_b = cmd.corr_issue ? cand + ADDR_W'(k) : pos_i + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  assign glen_prod = 29'(GRAIN_LEN) * 29'(ratio_c);
  assign ideal     = wi - glen_prod[FRAC_W +: ADDR_W];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      wi      <= WI_RST;
      gsel    <= 1'b0;
      pos_a   <= POS_A_RST;
      pos_b   <= POS_B_RST;
      ph_a    <= '0;
      ph_b    <= PH_W'(HALF);
      byp     <= 1'b0;
      k       <= '0;
      d       <= '0;
      have    <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      v1 <= cmd.corr_issue;
      v2 <= v1;
      if (cmd.clr_write) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.latch_in) byp <= status.bypass;
      if (cmd.write_sample) begin
        wi   <= wi + 1'b1;
        gsel <= 1'b0;
      end
      if (cmd.next_grain) gsel <= 1'b1;
      if (cmd.grain_upd) begin
        if (gsel) begin
          pos_b <= pos_b + POS_W'(ratio_c);
          ph_b  <= ph_next;
        end else begin
          pos_a <= pos_a + POS_W'(ratio_c);
          ph_a  <= ph_next;
        end
      end
      if (cmd.srch_end) begin
        if (gsel) pos_b <= {best_pos, FRAC_W'(0)};
        else pos_a <= {best_pos, FRAC_W'(0)};
      end
      if (cmd.srch_init) begin
        k    <= '0;
        d    <= '0;
        have <= 1'b0;
      end
      if (cmd.corr_issue) k <= status.tap_last ? '0 : k + 1'b1;
      if (cmd.srch_comp) begin
        d <= d + 1'b1;
        if (!have || score > best) have <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch_in) x <= sample_in;
    if (cmd.grain_read) begin
      win_q  <= win_tab[ph_sel];
      frac_q <= pos_sel[FRAC_W-1:0];
    end
    if (cmd.interp) begin
      interp_q <= $signed({{2{rd_a[SAMPLE_W-1]}}, rd_a, FRAC_W'(0)})
                + $signed({1'b0, frac_q}) * ($signed({rd_b[SAMPLE_W-1], rd_b})
                - $signed({rd_a[SAMPLE_W-1], rd_a}));
    end
    if (cmd.wmul) wprod_q <= interp_q * $signed({1'b0, win_q});
    if (cmd.grain_upd) begin
      if (gsel) gb <= 41'((wprod_q + 56'sd16384) >>> 15);
      else ga <= 41'((wprod_q + 56'sd16384) >>> 15);
    end
    if (cmd.srch_init) begin
      src   <= wi - ADDR_W'(CORR_TAPS);
      cand  <= ideal - ADDR_W'(SEARCH_RANGE);
      score <= '0;
    end
    if (v1) cprod_q <= rd_a * rd_b;
    if (v2) score <= score + SCORE_W'(cprod_q);
    if (cmd.srch_comp) begin
      if (!have || score > best) begin
        best     <= score;
        best_pos <= cand;
      end
      cand  <= cand + 1'b1;
      score <= '0;
    end
    if (cmd.mix1) begin
      p1_q <= x * $signed({1'b0, 17'd32768 - 17'(mix_c)});
      p2_q <= (42'(ga) + 42'(gb)) * $signed({1'b0, mix_c});
    end
    if (cmd.mix2) mixq_q <= 47'(p1_q) + 47'((p2_q + 59'sd4096) >>> 13);
    if (cmd.mix3) fin_q <= 64'(mixq_q * $signed({1'b0, level_c}));
    if (cmd.bypass_mul) fin_q <= 64'(x * $signed({1'b0, level_c}));
  end

  // output rounding and saturation
  logic signed [63:0] rnd_val;
  logic signed [SAMPLE_W-1:0] sat_val;

  always_comb begin
    if (byp) rnd_val = (fin_q + 64'sd16384) >>> 15;
    else rnd_val = (fin_q + 64'sd536870912) >>> 30;
    if (rnd_val > 64'sd8388607) sat_val = 24'sd8388607;
    else if (rnd_val < -64'sd8388608) sat_val = -24'sd8388608;
    else sat_val = rnd_val[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) sample_out <= sat_val;
  end

  assign status.clr_last  = (clr_cnt == ADDR_W'(DEPTH - 1));
  assign status.bypass    = (ratio_c >= UNITY - BYPASS_TOL) && (ratio_c <= UNITY + BYPASS_TOL);
  assign status.grain_end = (ph_sel == PH_W'(GRAIN_LEN - 1));
  assign status.gsel      = gsel;
  assign status.tap_last  = (k == K_W'(CORR_TAPS - 1));
  assign status.pipe_busy = v1 | v2;
  assign status.cand_last = (d == D_W'(2 * SEARCH_RANGE));

`ifndef NO_ASSERTIONS
  a_phase_spacing: assert property (@(posedge clk) disable iff (rst)
    cmd.latch_in |-> ({1'b0, ph_b} == ((({1'b0, ph_a} + (PH_W+1)'(HALF)) >= (PH_W+1)'(GRAIN_LEN))
      ? ({1'b0, ph_a} + (PH_W+1)'(HALF) - (PH_W+1)'(GRAIN_LEN))
      : ({1'b0, ph_a} + (PH_W+1)'(HALF)))))
    else $error("grain phases lost their half-grain spacing");

  a_best_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.srch_end |-> have)
    else $error("grain restart without a scored candidate");
`endif

endmodule

FILE: rtl/core/wsola_ctrl.sv
// ----------------------------------------------------------------------------
// wsola_ctrl
// Controller: clearing pass, bypass path, per-sample sequencing of both grains, the
// correlation search on grain end, mixing and the output handshake.
// ----------------------------------------------------------------------------
module wsola_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output wsola_pkg::cmd_t     cmd,
  input  wsola_pkg::status_t  status
);
  import wsola_pkg::*;

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_BYP    = 5'd2;
  localparam logic [4:0] S_WR     = 5'd3;
  localparam logic [4:0] S_GRD    = 5'd4;
  localparam logic [4:0] S_GM1    = 5'd5;
  localparam logic [4:0] S_GM2    = 5'd6;
  localparam logic [4:0] S_GM3    = 5'd7;
  localparam logic [4:0] S_SINIT  = 5'd8;
  localparam logic [4:0] S_SRUN   = 5'd9;
  localparam logic [4:0] S_SDRAIN = 5'd10;
  localparam logic [4:0] S_SCOMP  = 5'd11;
  localparam logic [4:0] S_SEND   = 5'd12;
  localparam logic [4:0] S_MX1    = 5'd13;
  localparam logic [4:0] S_MX2    = 5'd14;
  localparam logic [4:0] S_MX3    = 5'd15;
  localparam logic [4:0] S_FIN    = 5'd16;

  logic [4:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = status.bypass ? S_BYP : S_WR;
        end
      end
      S_BYP: begin
        cmd.bypass_mul = 1'b1;
        state_next     = S_FIN;
      end
      S_WR: begin
        cmd.write_sample = 1'b1;
        state_next       = S_GRD;
      end
      S_GRD: begin
        cmd.grain_read = 1'b1;
        state_next     = S_GM1;
      end
      S_GM1: begin
        cmd.interp = 1'b1;
        state_next = S_GM2;
      end
      S_GM2: begin
        cmd.wmul   = 1'b1;
        state_next = S_GM3;
      end
      S_GM3: begin
        cmd.grain_upd = 1'b1;
        if (status.grain_end) begin
          state_next = S_SINIT;
        end else if (!status.gsel) begin
          cmd.next_grain = 1'b1;
          state_next     = S_GRD;
        end else begin
          state_next = S_MX1;
        end
      end
      S_SINIT: begin
        cmd.srch_init = 1'b1;
        state_next    = S_SRUN;
      end
      S_SRUN: begin
        cmd.corr_issue = 1'b1;
        if (status.tap_last) state_next = S_SDRAIN;
      end
      S_SDRAIN: begin
        if (!status.pipe_busy) state_next = S_SCOMP;
      end
      S_SCOMP: begin
        cmd.srch_comp = 1'b1;
        state_next    = status.cand_last ? S_SEND : S_SRUN;
      end
      S_SEND: begin
        cmd.srch_end = 1'b1;
        if (!status.gsel) begin
          cmd.next_grain = 1'b1;
          state_next     = S_GRD;
        end else begin
          state_next = S_MX1;
        end
      end
      S_MX1: begin
        cmd.mix1   = 1'b1;
        state_next = S_MX2;
      end
      S_MX2: begin
        cmd.mix2   = 1'b1;
        state_next = S_MX3;
      end
      S_MX3: begin
        cmd.mix3   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before its transaction");

  a_score_settled: assert property (@(posedge clk) disable iff (rst)
    cmd.srch_comp |-> !status.pipe_busy)
    else $error("candidate compared before its sum settled");
`endif

endmodule

FILE: rtl/core/wsola_pitch_shifter_unit.sv
// ----------------------------------------------------------------------------
// wsola_pitch_shifter_unit
// Two-grain Hann-windowed overlap-add pitch shifter with correlation-aligned
// grain restarts over a circular delay line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one signed 24-bit sample per
//   transaction; output channel out_valid/out_ready returns one sample per
//   input. Registers (shift ratio, wet mix, output level) are written through
//   cfg_we/cfg_index/cfg_data while no transaction is in flight.
//   After reset the 8192-entry delay line is cleared one entry per cycle;
//   in_ready stays low until the clearing pass is done.
//   In bypass (ratio near unity) the sample only runs the level multiply.
//   One sample is in work at a time; the grain pair runs on one shared
//   interpolate/window multiplier.
//   When a grain ends (once every GRAIN_LEN/2 samples) the sample also runs
//   the correlation search over 2*SEARCH_RANGE + 1 candidates of CORR_TAPS
//   taps each, one multiply-accumulate per cycle on the two delay-line read
//   ports.
//   A stalled receiver holds the result register; the next sample is still
//   accepted and waits in its last step until the result is taken.
// ----------------------------------------------------------------------------
module wsola_pitch_shifter_unit #(
  parameter int GRAIN_LEN    = 1024,
  parameter int CORR_TAPS    = 64,
  parameter int SEARCH_RANGE = 150
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [wsola_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [wsola_pkg::SAMPLE_W-1:0] sample_out,
  input  logic                                  cfg_we,
  input  logic [wsola_pkg::IDX_W-1:0]           cfg_index,
  input  logic [wsola_pkg::CFG_W-1:0]           cfg_data
);
  import wsola_pkg::*;

  cmd_t    cmd;
  status_t status;

  wsola_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  wsola_dp #(
    .GRAIN_LEN    (GRAIN_LEN),
    .CORR_TAPS    (CORR_TAPS),
    .SEARCH_RANGE (SEARCH_RANGE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .sample_out (sample_out),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

FILE: dv/wsola_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wsola_checker
// Watches the sample and register ports of the pitch shifter, keeps its own
// fixed-point model of the delay line, the two windowed grains and the
// correlation search, and compares every output sample in order.
// ----------------------------------------------------------------------------
module wsola_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic signed [wsola_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [wsola_pkg::SAMPLE_W-1:0] sample_out,
  input  logic                                  cfg_we,
  input  logic [wsola_pkg::IDX_W-1:0]           cfg_index,
  input  logic [wsola_pkg::CFG_W-1:0]           cfg_data,
  output int                                    errors,
  output int                                    pending,
  output int                                    checked,
  output int                                    searches
);
  import wsola_pkg::*;

  localparam int  GRAIN   = 1024;
  localparam int  TAPS    = 64;
  localparam int  RANGE   = 150;
  localparam longint POS_MOD = longint'(DEPTH) << FRAC_W;

  logic signed [SAMPLE_W-1:0] expected_samples[$];
  longint                     line_mem[DEPTH];
  longint                     wr_idx;
  longint                     grain_pos[2];
  int                         grain_ph[2];
  longint                     hann_rom[GRAIN];
  logic [CFG_W-1:0]           ratio_reg, wet_reg, level_reg;

  function automatic longint wrap_addr(longint v);
    return ((v % DEPTH) + DEPTH) % DEPTH;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint hann_at(int k);
    longint unsigned m, x, x2, term, sq, q;
    longint          s;
    m = (k <= GRAIN / 2) ? k : GRAIN - k;
    x = (PI_Q30 * m) / GRAIN;
    x2 = (x * x) >> 30;
    term = x;
    s = x;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    if (s > (longint'(1) << 30)) s = longint'(1) << 30;
    sq = (longint'(s) * longint'(s)) >> 30;
    q = (sq + (1 << 14)) >> 15;
    if (q > 32768) q = 32768;
    return q;
  endfunction

  function automatic longint best_start(longint ratio);
    longint ideal, src, score, top_score;
    int     best_d;
    ideal = wrap_addr(wr_idx - ((GRAIN * ratio) >> FRAC_W));
    src = wr_idx - TAPS;
    top_score = 0;
    best_d = -RANGE;
    for (int d = -RANGE; d <= RANGE; d++) begin
      score = 0;
      for (int k = 0; k < TAPS; k++)
        score += line_mem[wrap_addr(src + k)] * line_mem[wrap_addr(ideal + d + k)];
      if (d == -RANGE || score > top_score) begin
        top_score = score;
        best_d = d;
      end
    end
    searches++;
    return wrap_addr(ideal + best_d);
  endfunction

  function automatic longint step_grain(int g, longint ratio);
    longint i0, frac, s0, s1, val;
    i0 = wrap_addr(grain_pos[g] >>> FRAC_W);
    frac = grain_pos[g] & (2 ** FRAC_W - 1);
    s0 = line_mem[i0];
    s1 = line_mem[wrap_addr(i0 + 1)];
    val = round_shift((s0 * 8192 + frac * (s1 - s0)) * hann_rom[grain_ph[g]], 15);
    grain_pos[g] = (grain_pos[g] + ratio) % POS_MOD;
    grain_ph[g]++;
    if (grain_ph[g] >= GRAIN) begin
      grain_ph[g] = 0;
      grain_pos[g] = best_start(ratio) << FRAC_W;
    end
    return val;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] shift_sample(longint x);
    longint ratio, mix, level, ga, gb, mixq;
    ratio = ratio_reg;
    mix = (wet_reg > GAIN_MAX) ? GAIN_MAX : wet_reg;
    level = (level_reg > GAIN_MAX) ? GAIN_MAX : level_reg;
    if (ratio < RATIO_MIN) ratio = RATIO_MIN;
    if (ratio > RATIO_MAX) ratio = RATIO_MAX;
    if (ratio >= UNITY - BYPASS_TOL && ratio <= UNITY + BYPASS_TOL)
      return clip24(round_shift(x * level, 15));
    line_mem[wr_idx] = x;
    wr_idx = wrap_addr(wr_idx + 1);
    ga = step_grain(0, ratio);
    gb = step_grain(1, ratio);
    mixq = round_shift(x * (32768 - mix) * 8192 + (ga + gb) * mix, 13);
    return clip24(round_shift(mixq * level, 30));
  endfunction

  initial begin
    errors = 0;
    checked = 0;
    searches = 0;
    for (int k = 0; k < GRAIN; k++) hann_rom[k] = hann_at(k);
  end

  assign pending = expected_samples.size();

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst) begin
      expected_samples.delete();
      foreach (line_mem[i]) line_mem[i] = 0;
      wr_idx = DEPTH / 2;
      grain_pos[0] = longint'(DEPTH / 2 - GRAIN) << FRAC_W;
      grain_pos[1] = longint'(DEPTH / 2 - GRAIN / 2) << FRAC_W;
      grain_ph[0] = 0;
      grain_ph[1] = GRAIN / 2;
      ratio_reg = PITCH_RST;
      wet_reg = WET_RST;
      level_reg = LEVEL_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PITCH: ratio_reg = cfg_data;
          REG_WET:   wet_reg = cfg_data;
          REG_LEVEL: level_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("sample_out: unexpected transaction, actual %0d", sample_out);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          checked++;
          if (sample_out !== want) begin
            $error("sample_out: expected %0d, actual %0d", want, sample_out);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_samples.push_back(shift_sample(longint'(sample_in)));
    end
  end
endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the pitch shifter: directed extremes and bypass edges, then
// random sample streams under several register settings and idle/stall
// patterns, with a long output hold-off. Checking lives in wsola_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import wsola_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int               LIMIT      = 3000000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       cfg_we = 1'b0;
  logic [IDX_W-1:0]           cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;

  int  errors, pending, checked, searches;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_off = 1'b0;
  int  cycles = 0;

  always #10 clk = ~clk;

  wsola_pitch_shifter_unit dut (.*);

  wsola_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk)
    out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);

  task automatic push_sample(logic signed [SAMPLE_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= v;
    #1;
    while (!in_ready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(3))
      0: return SAMPLE_W'($signed(SAMPLE_W'($urandom_range(2000))) - 1000);
      1: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_ratio();
    case ($urandom_range(9))
      0: return RATIO_MIN;
      1: return RATIO_MAX;
      2: return CFG_W'($urandom_range(65535));
      default: return CFG_W'($urandom_range(RATIO_MAX, RATIO_MIN));
    endcase
  endfunction

  function automatic bit pitch_bypass();
    return u_checker.ratio_reg >= UNITY - BYPASS_TOL && u_checker.ratio_reg <= UNITY + BYPASS_TOL;
  endfunction

  task automatic run_phase(int idle, int stall, int n, bit press);
    idle_pct = idle;
    stall_pct = stall;
    write_reg(REG_PITCH, rand_ratio());
    while (pitch_bypass()) write_reg(REG_PITCH, rand_ratio());
    write_reg(REG_WET, CFG_W'($urandom_range(9) == 0 ? $urandom_range(65535)
                                                     : $urandom_range(32768)));
    write_reg(REG_LEVEL, CFG_W'($urandom_range(9) == 0 ? 32'hFFFF
                                                       : $urandom_range(32768, 8192)));
    fork
      if (press) begin
        hold_off = 1'b1;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      repeat (n) push_sample(rand_sample());
    join
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_sample(24'sh7FFFFF);
    push_sample(24'sh800000);
    push_sample(24'sh000000);
    push_sample(-24'sd1);
    push_sample(24'sd1);
    push_sample(24'sh555555);
    push_sample(24'shAAAAAA);
    write_reg(REG_WET, 16'hFFFF);
    write_reg(REG_LEVEL, 16'hFFFF);
    write_reg(REG_PITCH, 16'd0);
    push_sample(24'sh7FFFFF);
    push_sample(24'sh800000);
    write_reg(REG_PITCH, UNITY);
    write_reg(REG_UNUSED, 16'd0);
    push_sample(24'sh7FFFFF);
    push_sample(24'sh800000);
    write_reg(REG_PITCH, UNITY + BYPASS_TOL);
    write_reg(REG_LEVEL, 16'd0);
    push_sample(24'sh7FFFFF);
    write_reg(REG_PITCH, UNITY - BYPASS_TOL);
    write_reg(REG_LEVEL, GAIN_MAX);
    push_sample(24'sh800000);
    write_reg(REG_PITCH, UNITY + BYPASS_TOL + 1);
    write_reg(REG_WET, 16'd0);
    push_sample(24'sh123456);
    write_reg(REG_PITCH, UNITY - BYPASS_TOL - 1);
    write_reg(REG_WET, GAIN_MAX);
    push_sample(-24'sd4660);
    write_reg(REG_PITCH, 16'hFFFF);
    push_sample(24'sh7FFFFF);
    push_sample(24'sh800000);

    run_phase(0, 0, 60, 1'b0);
    run_phase(80, 0, 60, 1'b1);
    run_phase(0, 80, 60, 1'b0);
    run_phase(26, 26, 60, 1'b0);
    run_phase(0, 0, 50, 1'b0);

    wait (pending == 0);
    repeat (50) @(negedge clk);
    $display("Checked %0d output samples across bypass and shifting settings,", checked);
    $display("including %0d grain restart searches and a long output hold-off.", searches);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
